// ----- rtl/humidity_temperature_frame_filter_top_assert.svh -----
// Assertion macros for the frame filter.
// Each macro checks a clocked implication on clk, disabled while rst_n is low.
`ifndef HUMIDITY_TEMPERATURE_FRAME_FILTER_TOP_ASSERT_SVH
`define HUMIDITY_TEMPERATURE_FRAME_FILTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define HTFF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define HTFF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define HTFF_ASSERT_SAME(lbl, ante, cons)
`define HTFF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/htff_pkg.sv -----
`default_nettype none
package htff_pkg;

  localparam int BYTE_W   = 8;
  localparam int CODE_W   = 20;
  localparam int HUM_W    = 14;
  localparam int TOUT_W   = 15;
  localparam int TEMP_W   = 16;
  localparam int KW       = 8;
  localparam int DIV_W    = 23;
  localparam int POS_W    = 3;
  localparam int FRAME_W  = 40;

  localparam logic [POS_W-1:0] POS_IDLE = 3'd0;
  localparam logic [POS_W-1:0] POS_LAST = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_BUSY  = 2'd1;
  localparam logic [1:0] STAT_UNCAL = 2'd2;

  localparam int STATUS_BUSY_BIT = 7;
  localparam int STATUS_CAL_BIT  = 3;

  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [14:0] TEMP_SPAN   = 15'd20000;
  localparam logic [15:0] TEMP_OFFSET = 16'd5000;
  localparam logic [KW-1:0] WEIGHT_RESET = 8'd8;

  typedef struct packed {
    logic              busy;
    logic              cal;
    logic [CODE_W-1:0] hcode;
    logic [CODE_W-1:0] tcode;
  } htff_job_t;

endpackage
`default_nettype wire

// ----- rtl/htff_front.sv -----
`default_nettype none
module htff_front import htff_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic              frame_start,
  output logic                   push,
  output htff_job_t              job
);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;

  always_comb begin
    pos_nxt   = pos_r;
    frame_nxt = frame_r;
    push      = 1'b0;
    if (accept) begin
      if (frame_start) begin
        frame_nxt = {{(FRAME_W-BYTE_W){1'b0}}, rx_byte};
        pos_nxt   = 3'd1;
      end else if (pos_r == POS_IDLE || pos_r > POS_LAST) begin
        pos_nxt = POS_IDLE;
      end else if (pos_r < POS_LAST) begin
        frame_nxt = {frame_r[FRAME_W-BYTE_W-1:0], rx_byte};
        pos_nxt   = pos_r + 3'd1;
      end else begin
        pos_nxt = POS_IDLE;
        push    = 1'b1;
      end
    end
  end

  // status byte sits in the top byte; codes straddle the middle byte
  always_comb begin
    job.busy  = frame_r[32 + STATUS_BUSY_BIT];
    job.cal   = frame_r[32 + STATUS_CAL_BIT];
    job.hcode = frame_r[31:12];
    job.tcode = {frame_r[11:0], rx_byte};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_IDLE;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/htff_queue.sv -----
`default_nettype none
module htff_queue import htff_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire htff_job_t push_data,
  input  wire logic      pop,
  output htff_job_t      pop_data,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  htff_job_t        mem [DEPTH];
  htff_job_t        rd_data_r;
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = (cnt_r == CNT_FULL);
  assign empty    = (cnt_r == '0);
  assign pop_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/htff_div.sv -----
`default_nettype none
module htff_div import htff_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [KW-1:0]    divisor,
  output logic      [DIV_W-1:0] quotient,
  output logic                  done
);

  // restoring divider, one quotient bit per cycle
  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] work_r;
  logic [KW-1:0]    rem_r, div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [KW:0]      rem_sh;
  logic             qbit;
  logic [KW:0]      rem_sub;

  always_comb begin
    rem_sh  = {rem_r, work_r[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, div_r};
    qbit    = (rem_sh >= {1'b0, div_r});
  end

  assign quotient = work_r;
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      work_r <= {work_r[DIV_W-2:0], qbit};
      rem_r  <= qbit ? rem_sub[KW-1:0] : rem_sh[KW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/htff_back.sv -----
`default_nettype none
module htff_back import htff_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [KW-1:0]     weight,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire htff_job_t         q_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic [HUM_W-1:0]       out_hum,
  output logic [TOUT_W-1:0]      out_temp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        status_r;
  logic [HUM_W-1:0]  hnew_r, filt_h_r;
  logic [TEMP_W-1:0] tnew_r, filt_t_r;
  logic [DIV_W-1:0]  num_h_r;
  logic [24:0]       num_t_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [HUM_W-1:0]  out_hum_r;
  logic [TOUT_W-1:0] out_temp_r;

  logic [KW-1:0]     k_eff, km1;
  logic [33:0]       prod_hs;
  logic [34:0]       prod_ts;
  logic [21:0]       prod_h;
  logic signed [24:0] prod_t;
  logic [24:0]       mag_t;
  logic              div_start, done_h, done_t;
  logic [DIV_W-1:0]  q_h, q_t;
  logic [TEMP_W-1:0] q_t16;
  logic              load_out;

  // zero weight acts as one
  assign k_eff = (weight == '0) ? 8'd1 : weight;
  assign km1   = k_eff - 8'd1;

  assign prod_hs = q_data.hcode * HUM_SPAN;
  assign prod_ts = q_data.tcode * TEMP_SPAN;
  assign prod_h  = filt_h_r * km1;
  assign prod_t  = $signed(filt_t_r) * $signed({1'b0, km1});
  assign mag_t   = num_t_r[24] ? (25'd0 - num_t_r) : num_t_r;
  assign q_t16   = q_t[TEMP_W-1:0];

  assign div_start = (state_r == S_DIV);
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  htff_div u_div_h (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_h_r),
    .divisor  (k_eff),
    .quotient (q_h),
    .done     (done_h)
  );

  htff_div u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_t[DIV_W-1:0]),
    .divisor  (k_eff),
    .quotient (q_t),
    .done     (done_t)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (!q_empty) state_nxt = S_LOAD;
      S_LOAD: state_nxt = q_data.busy ? S_DONE : S_MAC;
      S_MAC:  state_nxt = S_DIV;
      S_DIV:  state_nxt = S_WAIT;
      S_WAIT: if (done_h && done_t) state_nxt = S_DONE;
      S_DONE: if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) begin
      hnew_r   <= prod_hs[33:20];
      tnew_r   <= {1'b0, prod_ts[34:20]} - TEMP_OFFSET;
      status_r <= q_data.busy ? STAT_BUSY : (q_data.cal ? STAT_OK : STAT_UNCAL);
    end
    if (state_r == S_MAC) begin
      num_h_r <= DIV_W'(prod_h) + DIV_W'(hnew_r);
      num_t_r <= prod_t + 25'($signed(tnew_r));
    end
    if (load_out) begin
      out_status_r <= status_r;
      out_hum_r    <= filt_h_r;
      out_temp_r   <= filt_t_r[TOUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      filt_h_r    <= '0;
      filt_t_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_WAIT && done_h && done_t) begin
        filt_h_r <= q_h[HUM_W-1:0];
        filt_t_r <= num_t_r[24] ? (16'd0 - q_t16) : q_t16;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_hum    = out_hum_r;
  assign out_temp   = out_temp_r;

endmodule
`default_nettype wire

// ----- rtl/humidity_temperature_frame_filter_top.sv -----
// Channel  Dir  Payload                                   Request
// in_      in   tdata[7:0] rx_byte, tuser frame_start      one reply byte
// out_     out  tdata: humidity[13:0], temp[28:14]; tuser  one decoded reading
//               frame_status[1:0]
// cfg_     in   wr_data[7:0] filter_weight                  register write
//
// Bytes are taken one per cycle while the frame queue has room.
// Each completed frame holds the back end from pop to result register through these steps:
// pop, scaling multiply, multiply-accumulate, divider start, then a wait on
// two parallel 23-bit restoring dividers by the weight, then output load.
// Busy frames skip the math and go through pop, load and output only.
// Reset (rst_n low, synchronous) clears the filters, queue and weight (to 8).
// A stalled output holds its request; the front keeps taking bytes until the queue fills.
`default_nettype none
`include "humidity_temperature_frame_filter_top_assert.svh"
module humidity_temperature_frame_filter_top import htff_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tuser,   // [0] frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [13:0] humidity_out, [28:14] temperature_out
  output logic [1:0]       out_tuser,  // [1:0] frame_status
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data // [7:0] filter_weight
);

  logic [KW-1:0]     weight_r;
  logic              in_acc;
  logic              q_push, q_pop, q_full, q_empty;
  htff_job_t         push_job, pop_job;
  logic [1:0]        res_status;
  logic [HUM_W-1:0]  res_hum;
  logic [TOUT_W-1:0] res_temp;

  // smoothing divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
    end else if (cfg_wr_en) begin
      weight_r <= cfg_wr_data;
    end
  end

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  // front: byte framing and status bit extraction
  htff_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .rx_byte     (in_tdata),
    .frame_start (in_tuser),
    .push        (q_push),
    .job         (push_job)
  );

  // decouples framing from the arithmetic
  htff_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_job),
    .pop       (q_pop),
    .pop_data  (pop_job),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: scaling, IIR update, output register
  htff_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .weight     (weight_r),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (pop_job),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (res_status),
    .out_hum    (res_hum),
    .out_temp   (res_temp)
  );

  assign out_tdata = {3'b000, res_temp, res_hum};
  assign out_tuser = res_status;

  // a frame never completes into a full queue
  `HTFF_ASSERT_SAME(a_no_overflow, q_push, !q_full)
  // back end only pulls jobs that exist
  `HTFF_ASSERT_SAME(a_no_underflow, q_pop, !q_empty)
  // a pop with no push in the same cycle cannot leave the queue full on the next cycle
  `HTFF_ASSERT_NEXT(a_pop_frees, q_pop && !q_push, !q_full)
  // reported status is one of the three defined codes
  `HTFF_ASSERT_SAME(a_status_code, out_tvalid,
    out_tuser == STAT_OK || out_tuser == STAT_BUSY || out_tuser == STAT_UNCAL)

endmodule
`default_nettype wire
